/* rtl/crl_pkg.sv */
// ----------------------------------------------------------------------------
// crl_pkg
// Shared constants and types for the comment region lexer: character codes,
// region class codes, queue sizing and the result bundle passed from the
// lexer front end to the output sequencer.
// ----------------------------------------------------------------------------
package crl_pkg;

   // Queue sizing and bundle size
   localparam int CRL_QUEUE_DEPTH = 2;
   localparam int CRL_MAX_RESULTS = 4;
   localparam int CRL_IDX_W       = $clog2(CRL_MAX_RESULTS);

   // Character codes
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   // Region class codes
   localparam logic [2:0] CLS_CODE  = 3'd0;
   localparam logic [2:0] CLS_STR   = 3'd1;
   localparam logic [2:0] CLS_CHR   = 3'd2;
   localparam logic [2:0] CLS_LINE  = 3'd3;
   localparam logic [2:0] CLS_BLOCK = 3'd4;
   localparam logic [2:0] CLS_DOC   = 3'd5;

   // All labelled bytes caused by one request, in output order
   typedef struct packed {
      logic [CRL_MAX_RESULTS-1:0][7:0] text_bytes;
      logic [CRL_MAX_RESULTS-1:0][2:0] region_classes;
      logic [CRL_IDX_W-1:0]            last_idx;
      logic                            fin;
   } crl_bundle_type;

endpackage

/* rtl/crl_front.sv */
// ----------------------------------------------------------------------------
// crl_front
// Lexer front end. Accepts one request per cycle while the queue has room,
// advances the lexer mode and builds the bundle of labelled bytes the
// request causes. Opener bytes that are still unresolved produce no bundle.
// ----------------------------------------------------------------------------
module crl_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_text_byte,
   input  logic                    req_final_byte,
   input  logic                    queue_full,
   output logic                    push_valid,
   output crl_pkg::crl_bundle_type push_data
);
   import crl_pkg::*;

   typedef enum logic [3:0] {
      M_CODE, M_STR, M_STR_ESC, M_CHR, M_CHR_ESC, M_LINE,
      M_BLOCK, M_DOC, M_SL, M_SL_ST, M_SL_ST_ST
   } mode_type;

   mode_type mode_ff, mode_in;
   logic     star_ff, star_in;

   logic                            accept;
   logic [CRL_MAX_RESULTS-1:0][7:0] byte_v;
   logic [CRL_MAX_RESULTS-1:0][2:0] cls_v;
   logic [CRL_IDX_W:0]              n_v;
   logic [7:0]                      b;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;
   assign b         = req_text_byte;

   // Classify the byte and collect its results in order
   always_comb begin
      mode_in = mode_ff;
      star_in = star_ff;
      byte_v  = '0;
      cls_v   = '0;
      n_v     = '0;

      case (mode_ff)
         M_STR, M_CHR: begin
            if (b == CH_BSLASH) begin
               byte_v[n_v[CRL_IDX_W-1:0]] = b;
               cls_v[n_v[CRL_IDX_W-1:0]]  = (mode_ff == M_STR) ? CLS_STR : CLS_CHR;
               n_v = n_v + 1'b1;
               mode_in = (mode_ff == M_STR) ? M_STR_ESC : M_CHR_ESC;
            end else if ((mode_ff == M_STR && b == CH_DQUOTE) ||
                         (mode_ff == M_CHR && b == CH_SQUOTE)) begin
               byte_v[n_v[CRL_IDX_W-1:0]] = b;
               cls_v[n_v[CRL_IDX_W-1:0]]  = (mode_ff == M_STR) ? CLS_STR : CLS_CHR;
               n_v = n_v + 1'b1;
               mode_in = M_CODE;
            end else if (b == CH_NL) begin
               byte_v[n_v[CRL_IDX_W-1:0]] = b;
               cls_v[n_v[CRL_IDX_W-1:0]]  = CLS_CODE;
               n_v = n_v + 1'b1;
               mode_in = M_CODE;
            end else begin
               byte_v[n_v[CRL_IDX_W-1:0]] = b;
               cls_v[n_v[CRL_IDX_W-1:0]]  = (mode_ff == M_STR) ? CLS_STR : CLS_CHR;
               n_v = n_v + 1'b1;
            end
         end
         M_STR_ESC, M_CHR_ESC: begin
            byte_v[n_v[CRL_IDX_W-1:0]] = b;
            cls_v[n_v[CRL_IDX_W-1:0]]  = (mode_ff == M_STR_ESC) ? CLS_STR : CLS_CHR;
            n_v = n_v + 1'b1;
            mode_in = (mode_ff == M_STR_ESC) ? M_STR : M_CHR;
         end
         M_LINE: begin
            byte_v[n_v[CRL_IDX_W-1:0]] = b;
            cls_v[n_v[CRL_IDX_W-1:0]]  = (b == CH_NL) ? CLS_CODE : CLS_LINE;
            n_v = n_v + 1'b1;
            if (b == CH_NL) begin
               mode_in = M_CODE;
            end
         end
         M_BLOCK, M_DOC: begin
            byte_v[n_v[CRL_IDX_W-1:0]] = b;
            cls_v[n_v[CRL_IDX_W-1:0]]  = (mode_ff == M_BLOCK) ? CLS_BLOCK : CLS_DOC;
            n_v = n_v + 1'b1;
            if (star_ff && b == CH_SLASH) begin
               mode_in = M_CODE;
               star_in = 1'b0;
            end else begin
               star_in = (b == CH_STAR);
            end
         end
         M_SL: begin
            if (b == CH_SLASH) begin
               byte_v[0] = CH_SLASH;
               cls_v[0]  = CLS_LINE;
               byte_v[1] = b;
               cls_v[1]  = CLS_LINE;
               n_v = 3'(2);
               mode_in = M_LINE;
            end else if (b == CH_STAR) begin
               mode_in = M_SL_ST;
            end else begin
               // Lone slash is code, then lex the byte from code mode
               byte_v[0] = CH_SLASH;
               cls_v[0]  = CLS_CODE;
               n_v = 3'(1);
               if (b == CH_DQUOTE) begin
                  byte_v[1] = b;
                  cls_v[1]  = CLS_STR;
                  n_v = 3'(2);
                  mode_in = M_STR;
               end else if (b == CH_SQUOTE) begin
                  byte_v[1] = b;
                  cls_v[1]  = CLS_CHR;
                  n_v = 3'(2);
                  mode_in = M_CHR;
               end else begin
                  byte_v[1] = b;
                  cls_v[1]  = CLS_CODE;
                  n_v = 3'(2);
                  mode_in = M_CODE;
               end
            end
         end
         M_SL_ST: begin
            if (b == CH_STAR) begin
               mode_in = M_SL_ST_ST;
            end else begin
               // Opener resolves as block comment; body search starts fresh
               byte_v[0] = CH_SLASH;
               cls_v[0]  = CLS_BLOCK;
               byte_v[1] = CH_STAR;
               cls_v[1]  = CLS_BLOCK;
               byte_v[2] = b;
               cls_v[2]  = CLS_BLOCK;
               n_v = 3'(3);
               mode_in = M_BLOCK;
               star_in = 1'b0;
            end
         end
         M_SL_ST_ST: begin
            byte_v[0] = CH_SLASH;
            byte_v[1] = CH_STAR;
            byte_v[2] = CH_STAR;
            byte_v[3] = b;
            n_v = 3'(4);
            if (b == CH_STAR) begin
               // Third star makes a plain block comment and may close it
               cls_v   = {CLS_BLOCK, CLS_BLOCK, CLS_BLOCK, CLS_BLOCK};
               mode_in = M_BLOCK;
               star_in = 1'b1;
            end else begin
               cls_v   = {CLS_DOC, CLS_DOC, CLS_DOC, CLS_DOC};
               mode_in = M_DOC;
               star_in = (b == CH_STAR);
            end
         end
         default: begin
            if (b == CH_DQUOTE) begin
               byte_v[0] = b;
               cls_v[0]  = CLS_STR;
               n_v = 3'(1);
               mode_in = M_STR;
            end else if (b == CH_SQUOTE) begin
               byte_v[0] = b;
               cls_v[0]  = CLS_CHR;
               n_v = 3'(1);
               mode_in = M_CHR;
            end else if (b == CH_SLASH) begin
               mode_in = M_SL;
            end else begin
               byte_v[0] = b;
               cls_v[0]  = CLS_CODE;
               n_v = 3'(1);
               mode_in = M_CODE;
            end
         end
      endcase

      // Flush held opener bytes at end of text, then return to reset state
      if (req_final_byte) begin
         case (mode_in)
            M_SL: begin
               byte_v[n_v[CRL_IDX_W-1:0]] = CH_SLASH;
               cls_v[n_v[CRL_IDX_W-1:0]]  = CLS_CODE;
               n_v = n_v + 1'b1;
            end
            M_SL_ST: begin
               byte_v[n_v[CRL_IDX_W-1:0]] = CH_SLASH;
               cls_v[n_v[CRL_IDX_W-1:0]]  = CLS_BLOCK;
               n_v = n_v + 1'b1;
               byte_v[n_v[CRL_IDX_W-1:0]] = CH_STAR;
               cls_v[n_v[CRL_IDX_W-1:0]]  = CLS_BLOCK;
               n_v = n_v + 1'b1;
            end
            M_SL_ST_ST: begin
               byte_v[0] = CH_SLASH;
               cls_v[0]  = CLS_DOC;
               byte_v[1] = CH_STAR;
               cls_v[1]  = CLS_DOC;
               byte_v[2] = CH_STAR;
               cls_v[2]  = CLS_DOC;
               n_v = 3'(3);
            end
            default: begin
            end
         endcase
         mode_in = M_CODE;
         star_in = 1'b0;
      end
   end

   // Hand the bundle to the queue when the request produced any result
   always_comb begin
      push_valid              = accept && (n_v != '0);
      push_data.text_bytes     = byte_v;
      push_data.region_classes = cls_v;
      push_data.last_idx       = CRL_IDX_W'(n_v - 1'b1);
      push_data.fin            = req_final_byte;
   end

   // Advance lexer state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_CODE;
         star_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         star_ff <= star_in;
      end
   end

endmodule

/* rtl/crl_queue.sv */
// ----------------------------------------------------------------------------
// crl_queue
// Small FIFO of result bundles between the lexer front end and the output
// sequencer, so that each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module crl_queue #(
   parameter int DEPTH = crl_pkg::CRL_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  crl_pkg::crl_bundle_type push_data,
   output logic                    full,
   input  logic                    pop,
   output crl_pkg::crl_bundle_type pop_data,
   output logic                    empty
);
   import crl_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   crl_bundle_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the bundle storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/crl_back.sv */
// ----------------------------------------------------------------------------
// crl_back
// Output sequencer. Loads one bundle from the queue and emits its labelled
// bytes one per cycle while rsp_stall is low, marking the last one of each
// request and the end of text.
// ----------------------------------------------------------------------------
module crl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   input  crl_pkg::crl_bundle_type queue_data,
   output logic                    queue_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_labelled_byte,
   output logic [2:0]              rsp_region_class,
   output logic                    rsp_run_end,
   output logic                    rsp_text_end
);
   import crl_pkg::*;

   crl_bundle_type       cur_ff, cur_in;
   logic                 busy_ff, busy_in;
   logic [CRL_IDX_W-1:0] idx_ff, idx_in;
   logic                 last;
   logic                 take;

   assign last = (idx_ff == cur_ff.last_idx);
   assign take = busy_ff & ~rsp_stall;

   // Step through the bundle; load the next one when this one is done
   always_comb begin
      cur_in    = cur_ff;
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      queue_pop = 1'b0;
      if (!busy_ff || (take && last)) begin
         busy_in   = ~queue_empty;
         queue_pop = ~queue_empty;
         cur_in    = queue_data;
         idx_in    = '0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Hold the bundle payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_valid         = busy_ff;
   assign rsp_labelled_byte = cur_ff.text_bytes[idx_ff];
   assign rsp_region_class  = cur_ff.region_classes[idx_ff];
   assign rsp_run_end       = last;
   assign rsp_text_end      = last & cur_ff.fin;

endmodule

/* rtl/comment_region_lexer_unit.sv */
// ----------------------------------------------------------------------------
// comment_region_lexer_unit
// Labels each byte of a source text as code, string, char literal, line
// comment, block comment or doc comment.
// ----------------------------------------------------------------------------
// A request carries one text byte and may be accepted every cycle while the
// bundle queue has room. Each request yields zero to four results: zero while
// a slash, slash-star or slash-star-star opener is unresolved, and the held
// opener bytes come out together with the byte that resolves them or, on the
// final byte, after it. Results leave the output sequencer one per cycle while
// rsp_stall is low, and ordinary text runs at one byte per cycle while neither
// side stalls. A request's results pass from the lexer into the queue, then
// from the queue into the output register.
// rsp_run_end marks the last result of a request and rsp_text_end the last
// result of the text, after which the lexer is back in code mode.
// ----------------------------------------------------------------------------
module comment_region_lexer_unit #(
   parameter int QUEUE_DEPTH = crl_pkg::CRL_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_labelled_byte,
   output logic [2:0] rsp_region_class,
   output logic       rsp_run_end,
   output logic       rsp_text_end
);
   import crl_pkg::*;

   logic           queue_full;
   logic           queue_empty;
   logic           queue_pop;
   logic           push_valid;
   crl_bundle_type push_data;
   crl_bundle_type pop_data;

   crl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_final_byte (req_final_byte),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_data      (push_data)
   );

   crl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_data   (pop_data),
      .empty      (queue_empty)
   );

   crl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_data        (pop_data),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_labelled_byte (rsp_labelled_byte),
      .rsp_region_class  (rsp_region_class),
      .rsp_run_end       (rsp_run_end),
      .rsp_text_end      (rsp_text_end)
   );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for comment_region_lexer_unit. It streams short source
// texts into the lexer, predicts the labelled bytes of every accepted request
// with a behavioral lexer of its own, and checks the results in order. Each
// run has a directed part for openers, literals and flushing at the end of a
// text. A random part follows in four idling phases: none, sender, output, both.
// ----------------------------------------------------------------------------
module tb;
   import crl_pkg::*;

   typedef enum logic [3:0] {
      LEX_CODE,
      LEX_STR,
      LEX_STR_ESC,
      LEX_CHR,
      LEX_CHR_ESC,
      LEX_LINE,
      LEX_BLOCK,
      LEX_DOC,
      LEX_SLASH,
      LEX_SLASH_STAR,
      LEX_SLASH_STAR2
   } lex_mode_type;

   typedef struct {
      logic [7:0] text_byte;
      logic [2:0] region;
      bit         run_end;
      bit         text_end;
   } region_label_type;

   // Predict the labels of each request and check the lexer output against them
   class region_label_checker;
      lex_mode_type     mode;
      logic [7:0]       held_bytes [3];
      int               held_count;
      bit               star_pending;
      region_label_type step_labels [$];
      region_label_type expected_labels [$];
      int               mismatches;

      function new();
         clear_state();
         mismatches = 0;
      endfunction

      function void clear_state();
         mode         = LEX_CODE;
         held_count   = 0;
         star_pending = 1'b0;
      endfunction

      function void label(logic [7:0] b, logic [2:0] region);
         region_label_type l;
         if (step_labels.size() < CRL_MAX_RESULTS) begin
            l.text_byte = b;
            l.region    = region;
            l.run_end   = 1'b0;
            l.text_end  = 1'b0;
            step_labels = {step_labels, l};
         end
      endfunction

      function void release_held(logic [2:0] region);
         for (int i = 0; i < held_count; i++)
            label(held_bytes[i], region);
         held_count = 0;
      endfunction

      function void hold_byte(logic [7:0] b);
         if (held_count < 3) begin
            held_bytes[held_count] = b;
            held_count++;
         end
      endfunction

      function void code_byte(logic [7:0] b);
         if (b == CH_DQUOTE) begin
            label(b, CLS_STR);
            mode = LEX_STR;
         end else if (b == CH_SQUOTE) begin
            label(b, CLS_CHR);
            mode = LEX_CHR;
         end else if (b == CH_SLASH) begin
            hold_byte(b);
            mode = LEX_SLASH;
         end else begin
            label(b, CLS_CODE);
            mode = LEX_CODE;
         end
      endfunction

      // Escape, closing quote or newline; anything else stays in the literal
      function void literal_byte(logic [7:0] b, logic [7:0] quote, logic [2:0] region,
                                 lex_mode_type esc_mode);
         if (b == CH_BSLASH) begin
            label(b, region);
            mode = esc_mode;
         end else if (b == quote) begin
            label(b, region);
            mode = LEX_CODE;
         end else if (b == CH_NL) begin
            label(b, CLS_CODE);
            mode = LEX_CODE;
         end else begin
            label(b, region);
         end
      endfunction

      // Close the comment on a slash right after a star
      function void body_byte(logic [7:0] b, logic [2:0] region);
         label(b, region);
         if (star_pending && b == CH_SLASH) begin
            mode         = LEX_CODE;
            star_pending = 1'b0;
         end else begin
            star_pending = (b == CH_STAR);
         end
      endfunction

      function void note_request(logic [7:0] b, bit fin);
         int n;
         step_labels.delete();
         case (mode)
            LEX_STR:     literal_byte(b, CH_DQUOTE, CLS_STR, LEX_STR_ESC);
            LEX_STR_ESC: begin
               label(b, CLS_STR);
               mode = LEX_STR;
            end
            LEX_CHR:     literal_byte(b, CH_SQUOTE, CLS_CHR, LEX_CHR_ESC);
            LEX_CHR_ESC: begin
               label(b, CLS_CHR);
               mode = LEX_CHR;
            end
            LEX_LINE: begin
               if (b == CH_NL) begin
                  label(b, CLS_CODE);
                  mode = LEX_CODE;
               end else begin
                  label(b, CLS_LINE);
               end
            end
            LEX_BLOCK:   body_byte(b, CLS_BLOCK);
            LEX_DOC:     body_byte(b, CLS_DOC);
            LEX_SLASH: begin
               if (b == CH_SLASH) begin
                  release_held(CLS_LINE);
                  label(b, CLS_LINE);
                  mode = LEX_LINE;
               end else if (b == CH_STAR) begin
                  hold_byte(b);
                  mode = LEX_SLASH_STAR;
               end else begin
                  release_held(CLS_CODE);
                  code_byte(b);
               end
            end
            LEX_SLASH_STAR: begin
               if (b == CH_STAR) begin
                  hold_byte(b);
                  mode = LEX_SLASH_STAR2;
               end else begin
                  release_held(CLS_BLOCK);
                  mode         = LEX_BLOCK;
                  star_pending = 1'b0;
                  body_byte(b, CLS_BLOCK);
               end
            end
            LEX_SLASH_STAR2: begin
               // A third star makes a plain block comment that may already close
               if (b == CH_STAR) begin
                  release_held(CLS_BLOCK);
                  label(b, CLS_BLOCK);
                  mode         = LEX_BLOCK;
                  star_pending = 1'b1;
               end else begin
                  release_held(CLS_DOC);
                  mode         = LEX_DOC;
                  star_pending = 1'b0;
                  body_byte(b, CLS_DOC);
               end
            end
            default: code_byte(b);
         endcase

         // Flush an unresolved opener at the end of the text
         if (fin) begin
            if (mode == LEX_SLASH)
               release_held(CLS_CODE);
            else if (mode == LEX_SLASH_STAR)
               release_held(CLS_BLOCK);
            else if (mode == LEX_SLASH_STAR2)
               release_held(CLS_DOC);
            clear_state();
         end

         n = step_labels.size();
         if (n > 0) begin
            step_labels[n-1].run_end  = 1'b1;
            step_labels[n-1].text_end = fin;
         end
         expected_labels = {expected_labels, step_labels};
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic [7:0] b, logic [2:0] region, logic run_end, logic text_end);
         region_label_type want;
         if (expected_labels.size() == 0) begin
            report($sformatf("unexpected result byte %h class %0d", b, region));
         end else begin
            want = expected_labels.pop_front();
            if (b !== want.text_byte)
               report($sformatf("labelled_byte %h, want %h", b, want.text_byte));
            if (region !== want.region)
               report($sformatf("region_class %0d, want %0d (byte %h)", region, want.region,
                                want.text_byte));
            if (run_end !== want.run_end)
               report($sformatf("run_end %b, want %b (byte %h)", run_end, want.run_end,
                                want.text_byte));
            if (text_end !== want.text_end)
               report($sformatf("text_end %b, want %b (byte %h)", text_end, want.text_end,
                                want.text_byte));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_text_byte;
   logic       req_final_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_labelled_byte;
   logic [2:0] rsp_region_class;
   logic       rsp_run_end;
   logic       rsp_text_end;

   region_label_checker labels = new();

   int         send_idle_pct = 0;
   int         stall_pct     = 0;
   logic [7:0] text_q [$];

   comment_region_lexer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_text_byte     (req_text_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_labelled_byte (rsp_labelled_byte),
      .rsp_region_class  (rsp_region_class),
      .rsp_run_end       (rsp_run_end),
      .rsp_text_end      (rsp_text_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Check accepted results and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            labels.check_result(rsp_labelled_byte, rsp_region_class, rsp_run_end,
                                rsp_text_end);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Idle at random, then hold the request until it is taken
   task automatic send_request(input logic [7:0] text_byte, input bit final_byte);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= text_byte;
      req_final_byte <= final_byte;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      labels.note_request(text_byte, final_byte);
   endtask

   task automatic send_text(input string s, input bit ends_text);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], ends_text && (i == s.len() - 1));
   endtask

   // Append one byte to the text being built
   function automatic void append_byte(logic [7:0] b);
      text_q = {text_q, b};
   endfunction

   // Comment and literal bodies lean on the bytes that change the mode
   function automatic logic [7:0] body_char();
      case ($urandom_range(0, 9))
         0: return CH_STAR;
         1: return CH_SLASH;
         2: return CH_NL;
         3: return CH_BSLASH;
         4: return CH_DQUOTE;
         5: return CH_SQUOTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_body(int n);
      repeat (n) append_byte(body_char());
   endfunction

   function automatic void add_comment_close();
      if ($urandom_range(0, 4) != 0) begin
         append_byte(CH_STAR);
         append_byte(CH_SLASH);
      end
   endfunction

   // Append one token: mostly well-formed constructs, some noise
   function automatic void add_token();
      int n;
      n = $urandom_range(0, 5);
      case ($urandom_range(0, 11))
         0, 1: append_byte(8'($urandom_range(0, 255)));
         2: append_byte(8'($urandom_range(97, 122)));
         3: begin
            append_byte(CH_DQUOTE);
            add_body(n);
            if ($urandom_range(0, 3) != 0) append_byte(CH_DQUOTE);
         end
         4: begin
            append_byte(CH_SQUOTE);
            add_body(n);
            if ($urandom_range(0, 3) != 0) append_byte(CH_SQUOTE);
         end
         5: begin
            append_byte(CH_SLASH);
            append_byte(CH_SLASH);
            add_body(n);
            append_byte(CH_NL);
         end
         6, 7, 8: begin
            // Block, doc, or three-star and longer openers
            append_byte(CH_SLASH);
            append_byte(CH_STAR);
            repeat ($urandom_range(0, 3)) append_byte(CH_STAR);
            add_body(n);
            add_comment_close();
         end
         9: begin
            append_byte(CH_SLASH);
            append_byte(8'($urandom_range(97, 122)));
         end
         10: append_byte(CH_NL);
         default: append_byte(CH_SLASH);
      endcase
   endfunction

   initial begin
      int sent;
      int target;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_text_byte  <= 8'h00;
      req_final_byte <= 1'b0;
      rsp_stall      <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: slash-star-slash, doc opener followed by a slash, four stars
      send_text("/*/*/", 1'b1);
      send_text("/**/", 1'b1);
      send_text("/****/", 1'b1);
      // Escapes, newline in a string, backslash at the end of a char literal
      send_text("\"\\\"\n'\\", 1'b1);
      // Lone slash, line comment with byte extremes, lone slash at the end
      send_text("/a//", 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_text("\n/", 1'b1);
      // Unresolved slash-star at the end
      send_text("/*", 1'b1);

      // Random texts, one idling phase after another
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
         endcase
         sent = 0;
         while (sent < 40) begin
            text_q.delete();
            target = $urandom_range(1, 24);
            while (text_q.size() < target)
               add_token();
            foreach (text_q[i])
               send_request(text_q[i], i == text_q.size() - 1);
            sent += text_q.size();
         end
      end
      req_valid <= 1'b0;

      // Drain, then let the pipeline settle
      while (labels.expected_labels.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (labels.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Stop a hung run
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule
